// ===== design/tcs_pkg.sv =====
package tcs_pkg;

  localparam logic [2:0] OP_TICK      = 3'd0;
  localparam logic [2:0] OP_STATUS    = 3'd1;
  localparam logic [2:0] OP_LATCH     = 3'd2;
  localparam logic [2:0] OP_RELEASE   = 3'd3;
  localparam logic [2:0] OP_LATERAL   = 3'd4;
  localparam logic [2:0] OP_HEARTBEAT = 3'd5;
  localparam logic [2:0] OP_ESTOP     = 3'd6;

  localparam logic [1:0] MODE_OK    = 2'd0;
  localparam logic [1:0] MODE_LOST  = 2'd1;
  localparam logic [1:0] MODE_ESTOP = 2'd2;

  localparam logic [2:0] CFG_HEARTBEAT_TIMEOUT  = 3'd0;
  localparam logic [2:0] CFG_LATERAL_MIN_POS    = 3'd1;
  localparam logic [2:0] CFG_LATERAL_MAX_POS    = 3'd2;
  localparam logic [2:0] CFG_LATERAL_MIN_ANGLE  = 3'd3;
  localparam logic [2:0] CFG_LATERAL_MAX_ANGLE  = 3'd4;
  localparam logic [2:0] CFG_LATCH_OPEN_ANGLE   = 3'd5;
  localparam logic [2:0] CFG_LATCH_CLOSED_ANGLE = 3'd6;
  localparam logic [2:0] CFG_ESTOP_DETACHES     = 3'd7;

  localparam logic [16:0] SILENCE_MAX = 17'h1FFFF;

  localparam logic [15:0] RST_HEARTBEAT_TIMEOUT  = 16'd1000;
  localparam logic [15:0] RST_LATERAL_MIN_POS    = 16'd0;
  localparam logic [15:0] RST_LATERAL_MAX_POS    = 16'd3000;
  localparam logic [7:0]  RST_LATERAL_MIN_ANGLE  = 8'd0;
  localparam logic [7:0]  RST_LATERAL_MAX_ANGLE  = 8'd180;
  localparam logic [7:0]  RST_LATCH_OPEN_ANGLE   = 8'd0;
  localparam logic [7:0]  RST_LATCH_CLOSED_ANGLE = 8'd90;
  localparam logic [7:0]  RST_LATERAL_ANGLE      = 8'd0;

  typedef struct packed {
    logic [2:0]         operation;
    logic signed [31:0] sequence_req;
    logic signed [15:0] requested_pos;
  } in_t;

  typedef struct packed {
    logic signed [31:0] ack_sequence;
    logic               duplicate;
    logic [1:0]         link_state;
    logic               is_latched;
    logic signed [15:0] lateral_pos;
    logic signed [31:0] highest_sequence;
    logic [7:0]         latch_angle;
    logic [7:0]         lateral_angle;
    logic               latch_attached;
    logic               lateral_attached;
  } out_t;

  typedef struct packed {
    logic [15:0]        heartbeat_timeout;
    logic signed [15:0] lateral_min_pos;
    logic signed [15:0] lateral_max_pos;
    logic [7:0]         lateral_min_angle;
    logic [7:0]         lateral_max_angle;
    logic [7:0]         latch_open_angle;
    logic [7:0]         latch_closed_angle;
    logic               estop_detaches;
  } cfg_t;

  typedef struct packed {
    logic               start;
    logic [15:0]        offset;
    logic signed [8:0]  diff;
    logic [15:0]        den;
    logic [7:0]         min_angle;
  } ang_req_t;

  typedef struct packed {
    logic       busy;
    logic       done;
    logic [7:0] angle;
  } ang_rsp_t;

endpackage

// ===== design/tcs_cfg_regs.sv =====
module tcs_cfg_regs (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  logic [2:0]    cfg_index,
  input  logic [15:0]   cfg_wdata,
  output tcs_pkg::cfg_t cfg
);

  tcs_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.heartbeat_timeout  <= tcs_pkg::RST_HEARTBEAT_TIMEOUT;
      cfg_r.lateral_min_pos    <= tcs_pkg::RST_LATERAL_MIN_POS;
      cfg_r.lateral_max_pos    <= tcs_pkg::RST_LATERAL_MAX_POS;
      cfg_r.lateral_min_angle  <= tcs_pkg::RST_LATERAL_MIN_ANGLE;
      cfg_r.lateral_max_angle  <= tcs_pkg::RST_LATERAL_MAX_ANGLE;
      cfg_r.latch_open_angle   <= tcs_pkg::RST_LATCH_OPEN_ANGLE;
      cfg_r.latch_closed_angle <= tcs_pkg::RST_LATCH_CLOSED_ANGLE;
      cfg_r.estop_detaches     <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        tcs_pkg::CFG_HEARTBEAT_TIMEOUT:  cfg_r.heartbeat_timeout  <= cfg_wdata;
        tcs_pkg::CFG_LATERAL_MIN_POS:    cfg_r.lateral_min_pos    <= cfg_wdata;
        tcs_pkg::CFG_LATERAL_MAX_POS:    cfg_r.lateral_max_pos    <= cfg_wdata;
        tcs_pkg::CFG_LATERAL_MIN_ANGLE:  cfg_r.lateral_min_angle  <= cfg_wdata[7:0];
        tcs_pkg::CFG_LATERAL_MAX_ANGLE:  cfg_r.lateral_max_angle  <= cfg_wdata[7:0];
        tcs_pkg::CFG_LATCH_OPEN_ANGLE:   cfg_r.latch_open_angle   <= cfg_wdata[7:0];
        tcs_pkg::CFG_LATCH_CLOSED_ANGLE: cfg_r.latch_closed_angle <= cfg_wdata[7:0];
        tcs_pkg::CFG_ESTOP_DETACHES:     cfg_r.estop_detaches     <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== design/tcs_angle_unit.sv =====
module tcs_angle_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  tcs_pkg::ang_req_t req,
  output tcs_pkg::ang_rsp_t rsp
);

  localparam logic [2:0] A_IDLE = 3'd0;
  localparam logic [2:0] A_MUL  = 3'd1;
  localparam logic [2:0] A_PREP = 3'd2;
  localparam logic [2:0] A_DIV  = 3'd3;
  localparam logic [2:0] A_FIN  = 3'd4;

  logic [2:0]  st_r, st_nxt;
  logic [15:0] off_r;
  logic [7:0]  mag_r;
  logic        neg_r;
  logic [15:0] den_r;
  logic [7:0]  mina_r;
  logic [23:0] prod_r;
  logic [24:0] rem_r;
  logic [24:0] dvs_r;
  logic [7:0]  quo_r;
  logic [2:0]  cnt_r;
  logic [25:0] sub;
  logic        fits;

  // shared compare and subtract of the restoring divider
  assign sub  = {1'b0, rem_r} - {1'b0, dvs_r};
  assign fits = !sub[25];

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      A_IDLE: if (req.start) begin
        st_nxt = A_MUL;
      end
      A_MUL:  st_nxt = A_PREP;
      A_PREP: st_nxt = A_DIV;
      A_DIV:  if (cnt_r == 3'd0) begin
        st_nxt = A_FIN;
      end
      A_FIN:  st_nxt = A_IDLE;
      default: st_nxt = A_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= A_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (st_r)
      A_IDLE: if (req.start) begin
        off_r  <= req.offset;
        neg_r  <= req.diff[8];
        mag_r  <= req.diff[8] ? 8'(-req.diff) : req.diff[7:0];
        den_r  <= req.den;
        mina_r <= req.min_angle;
      end
      A_MUL: begin
        prod_r <= off_r * mag_r;
      end
      A_PREP: begin
        // round half away from zero: (2*prod + den) / (2*den), with prod = offset * mag
        rem_r <= {prod_r, 1'b0} + {9'd0, den_r};
        dvs_r <= {1'b0, den_r, 8'd0};
        quo_r <= 8'd0;
        cnt_r <= 3'd7;
      end
      A_DIV: begin
        if (fits) begin
          rem_r <= sub[24:0];
        end
        quo_r <= {quo_r[6:0], fits};
        dvs_r <= dvs_r >> 1;
        cnt_r <= cnt_r - 3'd1;
      end
      default: ;
    endcase
  end

  assign rsp.busy  = (st_r != A_IDLE);
  assign rsp.done  = (st_r == A_FIN);
  assign rsp.angle = neg_r ? (mina_r - quo_r) : (mina_r + quo_r);

endmodule

// ===== design/tool_command_supervisor.sv =====
// path: each input transaction passes through the execute and output states; a fresh lateral
// command whose max position lies above its min position also waits in the angle state
// (8 restoring divide steps plus multiply, setup and finish in the angle unit)
// throughput: one item at a time, a new item is taken once the previous result is registered
// reset: synchronous active-low rst_n returns the configuration registers and the
// supervisor state to their defaults and drops out_valid
module tool_command_supervisor (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  tcs_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output tcs_pkg::out_t out_data,
  input  logic          cfg_we,
  input  logic [2:0]    cfg_index,
  input  logic [15:0]   cfg_wdata
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_EXEC  = 2'd1;
  localparam logic [1:0] ST_ANGLE = 2'd2;
  localparam logic [1:0] ST_OUT   = 2'd3;

  tcs_pkg::cfg_t     cfg;
  tcs_pkg::ang_req_t ang_req;
  tcs_pkg::ang_rsp_t ang_rsp;
  tcs_pkg::in_t      item_r;
  tcs_pkg::out_t     out_r;

  logic [1:0]         state_r;
  logic [1:0]         mode_r;
  logic               latch_closed_r;
  logic signed [15:0] lat_target_r;
  logic [7:0]         lat_angle_r;
  logic signed [31:0] top_seq_r;
  logic [16:0]        silence_r;
  logic               latch_drv_r;
  logic               lat_drv_r;
  logic signed [31:0] ack_r;
  logic               dup_r;
  logic               out_valid_r;

  logic               is_cmd;
  logic               fresh;
  logic [16:0]        sil_inc;
  logic signed [15:0] clamp_lo;
  logic signed [15:0] clamp_pos;
  logic signed [16:0] den;
  logic               den_pos;
  logic               out_load;

  tcs_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  tcs_angle_unit u_angle (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (ang_req),
    .rsp   (ang_rsp)
  );

  always_comb begin
    is_cmd = (item_r.operation == tcs_pkg::OP_LATCH) ||
             (item_r.operation == tcs_pkg::OP_RELEASE) ||
             (item_r.operation == tcs_pkg::OP_LATERAL);
    fresh = $signed(item_r.sequence_req) > $signed(top_seq_r);
    sil_inc = (silence_r == tcs_pkg::SILENCE_MAX) ? silence_r : silence_r + 17'd1;
    clamp_lo = ($signed(item_r.requested_pos) < $signed(cfg.lateral_min_pos)) ?
               cfg.lateral_min_pos : item_r.requested_pos;
    clamp_pos = ($signed(clamp_lo) > $signed(cfg.lateral_max_pos)) ?
                cfg.lateral_max_pos : clamp_lo;
    den = {cfg.lateral_max_pos[15], cfg.lateral_max_pos} -
          {cfg.lateral_min_pos[15], cfg.lateral_min_pos};
    den_pos = !den[16] && (den != 17'sd0);

    ang_req.start     = (state_r == ST_EXEC) && fresh && den_pos &&
                        (item_r.operation == tcs_pkg::OP_LATERAL);
    ang_req.offset    = 16'(clamp_pos - cfg.lateral_min_pos);
    ang_req.diff      = $signed({1'b0, cfg.lateral_max_angle}) -
                        $signed({1'b0, cfg.lateral_min_angle});
    ang_req.den       = den[15:0];
    ang_req.min_angle = cfg.lateral_min_angle;

    out_load = (state_r == ST_OUT) && (!out_valid_r || out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      mode_r         <= tcs_pkg::MODE_OK;
      latch_closed_r <= 1'b0;
      lat_target_r   <= 16'sd0;
      lat_angle_r    <= tcs_pkg::RST_LATERAL_ANGLE;
      top_seq_r      <= 32'sd0;
      silence_r      <= 17'd0;
      latch_drv_r    <= 1'b1;
      lat_drv_r      <= 1'b1;
      out_valid_r    <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: if (in_valid) begin
          state_r <= ST_EXEC;
        end
        ST_EXEC: begin
          state_r <= ang_req.start ? ST_ANGLE : ST_OUT;
          case (item_r.operation)
            tcs_pkg::OP_TICK: begin
              silence_r <= sil_inc;
              if (mode_r == tcs_pkg::MODE_OK && sil_inc > {1'b0, cfg.heartbeat_timeout}) begin
                mode_r <= tcs_pkg::MODE_LOST;
              end
            end
            tcs_pkg::OP_STATUS: begin
              if (mode_r == tcs_pkg::MODE_OK &&
                  silence_r > {1'b0, cfg.heartbeat_timeout}) begin
                mode_r <= tcs_pkg::MODE_LOST;
              end
            end
            tcs_pkg::OP_LATCH, tcs_pkg::OP_RELEASE: if (fresh) begin
              top_seq_r      <= item_r.sequence_req;
              mode_r         <= tcs_pkg::MODE_OK;
              latch_drv_r    <= 1'b1;
              latch_closed_r <= (item_r.operation == tcs_pkg::OP_LATCH);
            end
            tcs_pkg::OP_LATERAL: if (fresh) begin
              top_seq_r    <= item_r.sequence_req;
              mode_r       <= tcs_pkg::MODE_OK;
              lat_target_r <= clamp_pos;
              lat_drv_r    <= 1'b1;
              if (!den_pos) begin
                lat_angle_r <= cfg.lateral_min_angle;
              end
            end
            tcs_pkg::OP_HEARTBEAT: begin
              silence_r <= 17'd0;
              if (mode_r == tcs_pkg::MODE_LOST) begin
                mode_r <= tcs_pkg::MODE_OK;
              end
            end
            tcs_pkg::OP_ESTOP: begin
              if (cfg.estop_detaches) begin
                latch_drv_r <= 1'b0;
                lat_drv_r   <= 1'b0;
              end
              mode_r <= tcs_pkg::MODE_ESTOP;
            end
            default: ;
          endcase
        end
        ST_ANGLE: if (ang_rsp.done) begin
          lat_angle_r <= ang_rsp.angle;
          state_r     <= ST_OUT;
        end
        ST_OUT: if (out_load) begin
          state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_data;
    end
    if (state_r == ST_EXEC) begin
      ack_r <= is_cmd ? item_r.sequence_req : 32'sd0;
      dup_r <= is_cmd && !fresh;
    end
    if (out_load) begin
      out_r.ack_sequence     <= ack_r;
      out_r.duplicate        <= dup_r;
      out_r.link_state       <= mode_r;
      out_r.is_latched       <= latch_closed_r;
      out_r.lateral_pos      <= lat_target_r;
      out_r.highest_sequence <= top_seq_r;
      out_r.latch_angle      <= latch_closed_r ? cfg.latch_closed_angle : cfg.latch_open_angle;
      out_r.lateral_angle    <= lat_angle_r;
      out_r.latch_attached   <= latch_drv_r;
      out_r.lateral_attached <= lat_drv_r;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_accept_exec : assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == ST_EXEC)
    else $error("accepted transaction did not enter execution");

  a_result_from_out : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == ST_OUT))
    else $error("result raised outside the output state");

  a_angle_idle : assert property (@(posedge clk) disable iff (!rst_n)
    ang_rsp.busy |-> state_r == ST_ANGLE || state_r == ST_EXEC)
    else $error("angle unit busy while supervisor not waiting on it");

  a_dup_keeps_seq : assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EXEC && is_cmd && !fresh |=> $stable(top_seq_r))
    else $error("duplicate transaction changed highest sequence");

endmodule
